>>> sv/b2rpl_pkg.sv
// Shared types, constants and helpers for the BLAKE2b round permute layer.
package b2rpl_pkg;

  // Frame geometry
  localparam int BLOCKS      = 128;
  localparam int TOTAL       = BLOCKS * 8;
  localparam int HALF        = TOTAL / 2;
  localparam int SCATTER_MUL = 109;
  localparam int IDX_STEP    = SCATTER_MUL % TOTAL;
  localparam int IDX_W       = $clog2(TOTAL);
  localparam int BLK_W       = (BLOCKS > 2) ? $clog2(BLOCKS) : 1;
  localparam int OUT_IDX_W   = 10;

  // G rotation amounts
  localparam int ROT0 = 32;
  localparam int ROT1 = 24;
  localparam int ROT2 = 16;
  localparam int ROT3 = 63;

  typedef logic [63:0]    word_t;
  typedef word_t [15:0]   blk_t;
  typedef word_t [7:0]    fold_t;

  // Rotate right by a constant amount
  function automatic word_t rotr(input word_t w, input int c);
    return (w >> c) | (w << (64 - c));
  endfunction

endpackage

>>> sv/b2rpl_front.sv
// Front end: gathers sixteen words into a block and pushes it to the queue.
module b2rpl_front
  import b2rpl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  word_t word_in,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  q_full,
  output logic  push,
  output blk_t  push_blk
);

  logic [3:0] wcnt;
  word_t      col [15];
  logic       take;

  // Only the closing word of a block needs room in the queue
  assign in_stall = (wcnt == 4'd15) && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = take && (wcnt == 4'd15);

  // Block image: fifteen held words plus the arriving one
  always_comb begin
    for (int k = 0; k < 15; k++) begin
      push_blk[k] = col[k];
    end
    push_blk[15] = word_in;
  end

  // Word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
    end else if (take) begin
      wcnt <= wcnt + 4'd1;
    end
  end

  // Collection shift line, oldest word at the bottom
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < 14; k++) begin
        col[k] <= col[k+1];
      end
      col[14] <= word_in;
    end
  end

endmodule

>>> sv/b2rpl_queue.sv
// Two-entry block queue between the collector and the round engine.
module b2rpl_queue
  import b2rpl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  blk_t push_blk,
  output logic q_full,
  output logic q_valid,
  input  logic pop,
  output blk_t q_blk
);

  blk_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign q_full  = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_blk   = mem[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_blk;
    end
  end

endmodule

>>> sv/b2rpl_round.sv
// Round engine: four G lanes, one quarter step per cycle, columns then diagonals each round.
module b2rpl_round
  import b2rpl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  blk_t  q_blk,
  output logic  pop,
  output logic  fold_valid,
  input  logic  fold_ready,
  output fold_t fold
);

  typedef enum logic [1:0] {E_IDLE, E_RUN, E_DONE} state_t;

  state_t     state;
  logic [2:0] step;
  blk_t       v;
  blk_t       nv;
  blk_t       dg;
  blk_t       ud;
  word_t      x;
  word_t      z;

  assign pop        = (state == E_IDLE) && q_valid;
  assign fold_valid = (state == E_DONE);

  // Fold to eight words
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      fold[j] = v[j] ^ v[j+8];
    end
  end

  // One quarter step of G on each of the four columns
  always_comb begin
    nv = v;
    x  = '0;
    z  = '0;
    for (int k = 0; k < 4; k++) begin
      if (!step[0]) begin
        // a += b; d = rotr(d ^ a)
        x = v[k] + v[4+k];
        z = v[12+k] ^ x;
        nv[k] = x;
      end else begin
        // c += d; b = rotr(b ^ c)
        x = v[8+k] + v[12+k];
        z = v[4+k] ^ x;
        nv[8+k] = x;
      end
      case (step[1:0])
        2'd0:    z = rotr(z, ROT0);
        2'd1:    z = rotr(z, ROT1);
        2'd2:    z = rotr(z, ROT2);
        default: z = rotr(z, ROT3);
      endcase
      if (!step[0]) begin
        nv[12+k] = z;
      end else begin
        nv[4+k] = z;
      end
    end
  end

  // Row rotations: diagonals become columns, and back
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        dg[4*r+k]           = nv[4*r+((k+r)%4)];
        ud[4*r+((k+r)%4)]   = nv[4*r+k];
      end
    end
  end

  // Sequencer and state words
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      step  <= '0;
    end else begin
      case (state)
        E_IDLE: begin
          if (q_valid) begin
            v     <= q_blk;
            step  <= '0;
            state <= E_RUN;
          end
        end
        E_RUN: begin
          step <= step + 3'd1;
          if (step == 3'd3) begin
            v <= dg;
          end else if (step == 3'd7) begin
            v     <= ud;
            state <= E_DONE;
          end else begin
            v <= nv;
          end
        end
        E_DONE: begin
          if (fold_ready) begin
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

>>> sv/b2rpl_emit.sv
// Result emitter: shifts out eight folded words with scattered indices.
module b2rpl_emit
  import b2rpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fold_valid,
  output logic                 fold_ready,
  input  fold_t                fold,
  output logic                 out_valid,
  input  logic                 out_stall,
  output word_t                out_word,
  output logic [OUT_IDX_W-1:0] out_index,
  output logic                 last_in_block,
  output logic                 last_in_frame
);

  localparam logic [IDX_W:0]   STEP_X  = (IDX_W+1)'(IDX_STEP);
  localparam logic [IDX_W:0]   TOTAL_X = (IDX_W+1)'(TOTAL);
  localparam logic [IDX_W-1:0] HALF_X  = IDX_W'(HALF);
  localparam logic [BLK_W-1:0] LAST_B  = BLK_W'(BLOCKS - 1);

  fold_t                  buf_w;
  logic [2:0]             cnt;
  logic                   busy;
  logic [IDX_W-1:0]       idx;
  logic [BLK_W-1:0]       blk;
  logic [IDX_W:0]         idx_sum;
  logic [IDX_W:0]         idx_red;
  logic [IDX_W+OUT_IDX_W-1:0] idx_wide;
  logic                   beat;

  assign fold_ready    = !busy;
  assign out_valid     = busy;
  assign out_word      = buf_w[0];
  assign last_in_block = (cnt == 3'd7);
  assign last_in_frame = (cnt == 3'd7) && (blk == LAST_B);
  assign beat          = busy && !out_stall;

  // Output index, low ten bits
  assign idx_wide  = {{OUT_IDX_W{1'b0}}, idx};
  assign out_index = idx_wide[OUT_IDX_W-1:0];

  // Next scattered index modulo the frame size
  always_comb begin
    idx_sum = {1'b0, idx} + STEP_X;
    idx_red = (idx_sum >= TOTAL_X) ? (idx_sum - TOTAL_X) : idx_sum;
  end

  // Control: beat count, block count, running index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      blk  <= '0;
      idx  <= HALF_X;
    end else if (beat) begin
      cnt <= cnt + 3'd1;
      idx <= idx_red[IDX_W-1:0];
      if (cnt == 3'd7) begin
        busy <= 1'b0;
        blk  <= (blk == LAST_B) ? '0 : blk + BLK_W'(1);
        if (blk == LAST_B) begin
          idx <= HALF_X;
        end
      end
    end else if (!busy && fold_valid) begin
      busy <= 1'b1;
      cnt  <= '0;
    end
  end

  // Word buffer, current result at the bottom
  always_ff @(posedge clk) begin
    if (beat) begin
      for (int j = 0; j < 7; j++) begin
        buf_w[j] <= buf_w[j+1];
      end
    end else if (!busy && fold_valid) begin
      buf_w <= fold;
    end
  end

endmodule

>>> sv/blake2b_round_permute_layer_unit.sv
// Top level: BLAKE2b message-free round layer with scattered output.
//
// Input channel (word_in, in_valid, in_stall): one 64-bit state word per beat,
// sixteen beats per block, one beat per cycle while out_stall is low;
// in_stall rises only on a block's last word while the 2-entry queue is full.
// Output channel (out_word, out_index, last_in_block, last_in_frame,
// out_valid, out_stall): eight beats per block, v[j] ^ v[j+8] for j = 0..7,
// last_in_block on the eighth, last_in_frame on the eighth of block BLOCKS-1.
// The sixteenth word of a block pushes it into the block queue; the round
// engine loads it, runs 8 quarter steps and hands the fold to the emitter,
// which presents one result per cycle while out_stall is low. The engine
// (load, 8 quarter steps, handoff) and the emitter (load, 8 beats) each
// finish a block before the next is collected, so input runs at full rate.
// When the receiver stalls, the current result holds; the emitter buffer,
// round engine and block queue then fill in turn before the input stalls.
// Reset (rst, synchronous) empties the queue, idles the engine and the
// emitter, and restarts word, block and index counts at the frame start.
module blake2b_round_permute_layer_unit
  import b2rpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  word_t                word_in,
  input  logic                 in_valid,
  output logic                 in_stall,
  output word_t                out_word,
  output logic [OUT_IDX_W-1:0] out_index,
  output logic                 last_in_block,
  output logic                 last_in_frame,
  output logic                 out_valid,
  input  logic                 out_stall
);

  logic  q_full;
  logic  push;
  blk_t  push_blk;
  logic  q_valid;
  logic  pop;
  blk_t  q_blk;
  logic  fold_valid;
  logic  fold_ready;
  fold_t fold;

  b2rpl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .word_in  (word_in),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_blk (push_blk)
  );

  b2rpl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_blk (push_blk),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_blk    (q_blk)
  );

  b2rpl_round u_round (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_blk      (q_blk),
    .pop        (pop),
    .fold_valid (fold_valid),
    .fold_ready (fold_ready),
    .fold       (fold)
  );

  b2rpl_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .fold_valid    (fold_valid),
    .fold_ready    (fold_ready),
    .fold          (fold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_index     (out_index),
    .last_in_block (last_in_block),
    .last_in_frame (last_in_frame)
  );

endmodule
